### design/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helper functions for the wheel odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // encoder counter span used for wrap correction
    localparam int COUNT_SPAN = 65536;
    localparam logic signed [17:0] SPAN_S = 18'(COUNT_SPAN);

    // angle constants, Q29 radians
    localparam logic [31:0] PI_Q29      = 32'd1686629713;
    localparam logic [31:0] HALF_PI_Q29 = 32'd843314857;
    localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;

    // CORDIC
    localparam int          CORDIC_STEPS = 30;
    localparam int          COR_W        = 34;
    localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;

    // speed scaling
    localparam logic [31:0] US_PER_S  = 32'd1000000;
    localparam int          LIN_SHIFT = 16;
    localparam int          ANG_SHIFT = 13;

    // shared multiplier and divider widths
    localparam int MUL_A_W = 56;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 80;
    localparam int DIV_D_W = 32;
    localparam int DIV_S_W = 6;
    localparam int RNUM_W  = 76;

    // divider step counts (two bits per step)
    localparam logic [DIV_S_W-1:0] WRAP_STEPS = 6'd29;
    localparam logic [DIV_S_W-1:0] RATE_STEPS = 6'd38;

    // configuration register indexes
    localparam logic [1:0] CFG_MPC = 2'd0;
    localparam logic [1:0] CFG_ITW = 2'd1;
    localparam logic [1:0] CFG_THR = 2'd2;

    // configuration reset values
    localparam logic [31:0] MPC_RST = 32'd431541;
    localparam logic [31:0] ITW_RST = 32'd28926269;
    localparam logic [15:0] THR_RST = 16'd30000;

    typedef struct packed {
        logic [15:0] left_count;
        logic [15:0] right_count;
        logic [23:0] elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic               valid_res;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST_L,
        ST_DIST_R,
        ST_TURN,
        ST_WRAP_A,
        ST_ROTATE,
        ST_STEP_X,
        ST_STEP_Y,
        ST_WRAP_H,
        ST_LIN_MUL,
        ST_LIN_DIV,
        ST_ANG_MUL,
        ST_ANG_DIV,
        ST_DONE
    } t_state;

    typedef logic [CORDIC_STEPS-1:0][31:0] t_atan_tab;

    // atan(2^-i) in Q29 from the odd power series in Q62, rounded
    function automatic logic [31:0] atan_q29(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] term;
        int unsigned k;
        sum = 64'd0;
        if (i == 0) begin
            return 32'd421657428;
        end
        for (k = 1; i * k < 62; k += 2) begin
            term = (64'h4000_0000_0000_0000 >> (i * k)) / 64'(k);
            if (((k >> 1) & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        sum = (sum + 64'h1_0000_0000) >> 33;
        return sum[31:0];
    endfunction

    function automatic t_atan_tab atan_table();
        t_atan_tab t;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            t[i] = atan_q29(i);
        end
        return t;
    endfunction

    localparam t_atan_tab ATAN_TAB = atan_table();

    // count delta with wrap correction
    function automatic logic signed [17:0] fix_delta(input logic signed [17:0] d,
                                                     input logic [15:0] thr);
        logic signed [17:0] t;
        t = $signed({2'b00, thr});
        if (d > t) begin
            return d - SPAN_S;
        end else if (d < -t) begin
            return d + SPAN_S;
        end
        return d;
    endfunction

    // remainder of |v| by 2*pi plus sign of v -> angle in (-pi, pi]
    function automatic logic [31:0] wrap_fix(input logic neg, input logic [31:0] u);
        logic [32:0] r;
        r = (neg && (u != 32'd0)) ? ({1'b0, TWO_PI_Q29} - {1'b0, u}) : {1'b0, u};
        if (r > {1'b0, PI_Q29}) begin
            r = r - {1'b0, TWO_PI_Q29};
        end
        return r[31:0];
    endfunction

    // saturate a shifted magnitude quotient and apply the sign
    function automatic logic [31:0] rate_fix(input logic neg, input logic [RNUM_W-1:0] t);
        logic [31:0] lim;
        logic [31:0] mag;
        lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        mag = (t > RNUM_W'(lim)) ? lim : t[31:0];
        return neg ? (32'd0 - mag) : mag;
    endfunction

endpackage

### design/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul
// Shared unsigned multiplier: 56 x 32 bits in two 32 x 32 partial products.
// ----------------------------------------------------------------------------
module ddo_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ddo_pkg::MUL_A_W-1:0]   i_a,
    input  logic [ddo_pkg::MUL_B_W-1:0]   i_b,
    output logic [ddo_pkg::MUL_P_W-1:0]   o_p,
    output logic                          o_done
);

    logic [1:0]                        r_cnt, n_cnt;
    logic [63:0]                       r_prod, n_prod;
    logic [ddo_pkg::MUL_P_W-1:0]       r_acc, n_acc;
    logic                              r_done, n_done;
    logic [31:0]                       m_a;

    // one 32x32 multiplier: low half first, high half second
    assign m_a = (r_cnt == 2'd1) ? 32'(i_a[ddo_pkg::MUL_A_W-1:32]) : i_a[31:0];

    always_comb begin
        n_cnt  = r_cnt;
        n_prod = r_prod;
        n_acc  = r_acc;
        n_done = 1'b0;
        case (r_cnt)
            2'd0: begin
                if (i_start) begin
                    n_prod = 64'(m_a) * 64'(i_b);
                    n_cnt  = 2'd1;
                end
            end
            2'd1: begin
                n_acc  = ddo_pkg::MUL_P_W'(r_prod);
                n_prod = 64'(m_a) * 64'(i_b);
                n_cnt  = 2'd2;
            end
            2'd2: begin
                n_acc  = r_acc + {r_prod[ddo_pkg::MUL_P_W-33:0], 32'd0};
                n_cnt  = 2'd0;
                n_done = 1'b1;
            end
            default: begin
                n_cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    assign o_p    = r_acc;
    assign o_done = r_done;

endmodule

### design/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// Shared restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ddo_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ddo_pkg::DIV_N_W-1:0]   i_num,
    input  logic [ddo_pkg::DIV_D_W-1:0]   i_den,
    input  logic [ddo_pkg::DIV_S_W-1:0]   i_steps,
    output logic [ddo_pkg::DIV_N_W-1:0]   o_quo,
    output logic [ddo_pkg::DIV_D_W-1:0]   o_rem,
    output logic                          o_done
);

    localparam int NW = ddo_pkg::DIV_N_W;
    localparam int DW = ddo_pkg::DIV_D_W;

    logic [NW-1:0]                 r_nq, n_nq;
    logic [DW-1:0]                 r_rem, n_rem;
    logic [DW-1:0]                 r_den;
    logic [ddo_pkg::DIV_S_W-1:0]   r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;

    // numerator is left aligned; quotient bits enter at the bottom
    always_comb begin
        logic [DW:0]   rem2;
        logic          ge;
        n_nq   = r_nq;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        rem2   = '0;
        ge     = 1'b0;
        if (i_start) begin
            n_nq   = i_num;
            n_rem  = '0;
            n_cnt  = i_steps;
            n_busy = 1'b1;
        end else if (r_busy) begin
            for (int j = 0; j < 2; j++) begin
                rem2  = {n_rem, n_nq[NW-1]};
                ge    = (rem2 >= {1'b0, r_den});
                rem2  = ge ? (rem2 - {1'b0, r_den}) : rem2;
                n_rem = rem2[DW-1:0];
                n_nq  = {n_nq[NW-2:0], ge};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ddo_pkg::DIV_S_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_nq  <= n_nq;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_quo  = r_nq;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

### design/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation CORDIC: angle in Q29 to cosine and sine in Q30.
// ----------------------------------------------------------------------------
module ddo_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [31:0]                 i_angle,
    output logic signed [ddo_pkg::COR_W-1:0]   o_cos,
    output logic signed [ddo_pkg::COR_W-1:0]   o_sin,
    output logic                               o_done
);

    localparam int W = ddo_pkg::COR_W;

    logic signed [W-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic                r_neg, n_neg;
    logic [4:0]          r_i, n_i;
    logic                r_busy, n_busy;
    logic                r_done, n_done;

    logic signed [W-1:0] z_in, xs, ys, at;

    assign z_in = W'(i_angle);
    assign xs   = r_x >>> r_i;
    assign ys   = r_y >>> r_i;
    assign at   = $signed(W'(ddo_pkg::ATAN_TAB[r_i]));

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_neg  = r_neg;
        n_i    = r_i;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            // fold into [-pi/2, pi/2], negate the result afterwards
            n_x    = $signed(W'(ddo_pkg::CORDIC_GAIN));
            n_y    = '0;
            n_i    = 5'd0;
            n_busy = 1'b1;
            n_neg  = 1'b0;
            n_z    = z_in;
            if (z_in > $signed(W'(ddo_pkg::HALF_PI_Q29))) begin
                n_z   = z_in - $signed(W'(ddo_pkg::PI_Q29));
                n_neg = 1'b1;
            end else if (z_in < -$signed(W'(ddo_pkg::HALF_PI_Q29))) begin
                n_z   = z_in + $signed(W'(ddo_pkg::PI_Q29));
                n_neg = 1'b1;
            end
        end else if (r_busy) begin
            if (r_z >= 0) begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - at;
            end else begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + at;
            end
            n_i = r_i + 5'd1;
            if (r_i == 5'(ddo_pkg::CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_i    <= n_i;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_neg <= n_neg;
    end

    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;
    assign o_done = r_done;

endmodule

### design/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive wheel odometry: encoder counts in, pose and speeds out.
// ----------------------------------------------------------------------------
// One item per encoder sample, one result item per input item. The first
// item after reset only primes the count reference (valid_res = 0) and skips
// the arithmetic. Every later item runs seven operations on the shared
// 56x32 multiplier, a 30-step CORDIC, and four passes of the shared divider
// at two bits a cycle (29 steps for each heading wrap, 38 steps for each
// speed quotient). Input stall stays high from acceptance until the result
// has been placed in the output register; that register holds a finished
// item while the downstream side stalls. Configuration writes are taken at
// any time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module diff_drive_odometry (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ddo_pkg::t_in_item    i_in_item,
    // result item channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ddo_pkg::t_out_item   o_out_item,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // ---------------- registers ----------------
    ddo_pkg::t_state r_state, n_state;
    logic            r_issued, n_issued;

    logic [31:0]     r_mpc, r_itw;
    logic [15:0]     r_thr;

    logic            r_primed, n_primed;
    logic [15:0]     r_last_l, n_last_l, r_last_r, n_last_r;
    logic [31:0]     r_x, n_x, r_y, n_y;
    logic [31:0]     r_theta, n_theta;

    // per-item working values
    logic [23:0]               r_dt, n_dt;
    logic                      r_dl_neg, n_dl_neg, r_dr_neg, n_dr_neg;
    logic [16:0]               r_dl_mag, n_dl_mag, r_dr_mag, n_dr_mag;
    logic signed [49:0]        r_distl, n_distl, r_distr, n_distr;
    logic signed [56:0]        r_dth, n_dth;
    logic [31:0]               r_ang, n_ang;
    logic signed [ddo_pkg::COR_W-1:0] r_cos, n_cos, r_sin, n_sin;
    logic [ddo_pkg::RNUM_W-1:0] r_rnum, n_rnum;
    logic [31:0]               r_vlin, n_vlin, r_vang, n_vang;
    logic                      r_vres, n_vres;

    logic                 r_out_valid, n_out_valid;
    ddo_pkg::t_out_item   r_out_item, n_out_item;

    // ---------------- shared units ----------------
    logic                          mul_start, mul_done;
    logic [ddo_pkg::MUL_A_W-1:0]   mul_a;
    logic [ddo_pkg::MUL_B_W-1:0]   mul_b;
    logic [ddo_pkg::MUL_P_W-1:0]   mul_p;

    logic                          div_start, div_done;
    logic [ddo_pkg::DIV_N_W-1:0]   div_num, div_quo;
    logic [ddo_pkg::DIV_D_W-1:0]   div_den, div_rem;
    logic [ddo_pkg::DIV_S_W-1:0]   div_steps;

    logic                                cor_start, cor_done;
    logic signed [ddo_pkg::COR_W-1:0]    cor_cos, cor_sin;

    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_p     (mul_p),
        .o_done  (mul_done)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_quo   (div_quo),
        .o_rem   (div_rem),
        .o_done  (div_done)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle ($signed(r_ang)),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin),
        .o_done  (cor_done)
    );

    // ---------------- handshake ----------------
    logic in_acc, out_free, unit_done;

    assign o_in_stall = (r_state != ddo_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign unit_done  = mul_done || div_done || cor_done;

    // ---------------- derived datapath values ----------------
    // count deltas against the stored reference, wrap corrected
    logic signed [17:0] dl, dr;
    assign dl = ddo_pkg::fix_delta($signed({2'b00, i_in_item.left_count})
                                   - $signed({2'b00, r_last_l}), r_thr);
    assign dr = ddo_pkg::fix_delta($signed({2'b00, i_in_item.right_count})
                                   - $signed({2'b00, r_last_r}), r_thr);

    // travel = floor((l + r) / 2), turn difference = r - l
    logic signed [50:0] sum_lr, travel, diff;
    logic               trav_neg, diff_neg, dth_neg;
    logic [50:0]        trav_mag, diff_mag;
    logic [56:0]        dth_mag;
    assign sum_lr   = 51'(r_distl) + 51'(r_distr);
    assign travel   = sum_lr >>> 1;
    assign diff     = 51'(r_distr) - 51'(r_distl);
    assign trav_neg = travel[50];
    assign diff_neg = diff[50];
    assign dth_neg  = r_dth[56];
    assign trav_mag = trav_neg ? 51'(-travel) : 51'(travel);
    assign diff_mag = diff_neg ? 51'(-diff) : 51'(diff);
    assign dth_mag  = dth_neg ? 57'(-r_dth) : 57'(r_dth);

    // heading +/- turn, as magnitude and sign for the mod-2pi pass
    logic signed [57:0] ang_sub, ang_add, ang_v;
    logic [57:0]        ang_mag;
    assign ang_sub = 58'($signed(r_theta)) - 58'(r_dth);
    assign ang_add = 58'($signed(r_theta)) + 58'(r_dth);
    assign ang_v   = (r_state == ddo_pkg::ST_WRAP_A) ? ang_sub : ang_add;
    assign ang_mag = ang_v[57] ? 58'(-ang_v) : 58'(ang_v);

    logic [ddo_pkg::COR_W-1:0] cos_mag, sin_mag;
    assign cos_mag = r_cos[ddo_pkg::COR_W-1] ? ddo_pkg::COR_W'(-r_cos) : r_cos;
    assign sin_mag = r_sin[ddo_pkg::COR_W-1] ? ddo_pkg::COR_W'(-r_sin) : r_sin;

    // position increments: product >> 46, low 32 bits, signed
    logic [31:0] inc_mag;
    logic        inc_neg;
    assign inc_mag = mul_p[77:46];
    assign inc_neg = trav_neg ^ ((r_state == ddo_pkg::ST_STEP_X) ?
                                 r_cos[ddo_pkg::COR_W-1] : r_sin[ddo_pkg::COR_W-1]);

    logic [49:0] dist_p;
    assign dist_p = {1'b0, mul_p[48:0]};

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ddo_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = r_primed ? ddo_pkg::ST_DIST_L : ddo_pkg::ST_DONE;
                end
            end
            ddo_pkg::ST_DIST_L:  if (unit_done) n_state = ddo_pkg::ST_DIST_R;
            ddo_pkg::ST_DIST_R:  if (unit_done) n_state = ddo_pkg::ST_TURN;
            ddo_pkg::ST_TURN:    if (unit_done) n_state = ddo_pkg::ST_WRAP_A;
            ddo_pkg::ST_WRAP_A:  if (unit_done) n_state = ddo_pkg::ST_ROTATE;
            ddo_pkg::ST_ROTATE:  if (unit_done) n_state = ddo_pkg::ST_STEP_X;
            ddo_pkg::ST_STEP_X:  if (unit_done) n_state = ddo_pkg::ST_STEP_Y;
            ddo_pkg::ST_STEP_Y:  if (unit_done) n_state = ddo_pkg::ST_WRAP_H;
            ddo_pkg::ST_WRAP_H:  if (unit_done) n_state = ddo_pkg::ST_LIN_MUL;
            ddo_pkg::ST_LIN_MUL: if (unit_done) n_state = ddo_pkg::ST_LIN_DIV;
            ddo_pkg::ST_LIN_DIV: if (unit_done) n_state = ddo_pkg::ST_ANG_MUL;
            ddo_pkg::ST_ANG_MUL: if (unit_done) n_state = ddo_pkg::ST_ANG_DIV;
            ddo_pkg::ST_ANG_DIV: if (unit_done) n_state = ddo_pkg::ST_DONE;
            ddo_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ddo_pkg::ST_IDLE;
                end
            end
            default: n_state = ddo_pkg::ST_IDLE;
        endcase
    end

    // ---------------- unit launch and operand selection ----------------
    always_comb begin
        mul_start = 1'b0;
        div_start = 1'b0;
        cor_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_num   = '0;
        div_den   = ddo_pkg::TWO_PI_Q29;
        div_steps = ddo_pkg::WRAP_STEPS;
        case (r_state)
            ddo_pkg::ST_DIST_L: begin
                mul_start = !r_issued;
                mul_a     = ddo_pkg::MUL_A_W'(r_dl_mag);
                mul_b     = r_mpc;
            end
            ddo_pkg::ST_DIST_R: begin
                mul_start = !r_issued;
                mul_a     = ddo_pkg::MUL_A_W'(r_dr_mag);
                mul_b     = r_mpc;
            end
            ddo_pkg::ST_TURN: begin
                mul_start = !r_issued;
                mul_a     = ddo_pkg::MUL_A_W'(diff_mag);
                mul_b     = r_itw;
            end
            ddo_pkg::ST_WRAP_A, ddo_pkg::ST_WRAP_H: begin
                // 58-bit magnitude, left aligned in the numerator
                div_start = !r_issued;
                div_num   = {ang_mag, 22'd0};
            end
            ddo_pkg::ST_ROTATE: begin
                cor_start = !r_issued;
            end
            ddo_pkg::ST_STEP_X: begin
                mul_start = !r_issued;
                mul_a     = ddo_pkg::MUL_A_W'(trav_mag);
                mul_b     = cos_mag[31:0];
            end
            ddo_pkg::ST_STEP_Y: begin
                mul_start = !r_issued;
                mul_a     = ddo_pkg::MUL_A_W'(trav_mag);
                mul_b     = sin_mag[31:0];
            end
            ddo_pkg::ST_LIN_MUL: begin
                mul_start = !r_issued;
                mul_a     = ddo_pkg::MUL_A_W'(trav_mag);
                mul_b     = ddo_pkg::US_PER_S;
            end
            ddo_pkg::ST_ANG_MUL: begin
                mul_start = !r_issued;
                mul_a     = dth_mag[ddo_pkg::MUL_A_W-1:0];
                mul_b     = ddo_pkg::US_PER_S;
            end
            ddo_pkg::ST_LIN_DIV, ddo_pkg::ST_ANG_DIV: begin
                div_start = !r_issued;
                div_num   = {r_rnum, 4'd0};
                div_den   = 32'(r_dt);
                div_steps = ddo_pkg::RATE_STEPS;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign n_issued = unit_done ? 1'b0 :
                      ((mul_start || div_start || cor_start) ? 1'b1 : r_issued);

    // ---------------- datapath updates ----------------
    always_comb begin
        n_primed    = r_primed;
        n_last_l    = r_last_l;
        n_last_r    = r_last_r;
        n_x         = r_x;
        n_y         = r_y;
        n_theta     = r_theta;
        n_dt        = r_dt;
        n_dl_neg    = r_dl_neg;
        n_dl_mag    = r_dl_mag;
        n_dr_neg    = r_dr_neg;
        n_dr_mag    = r_dr_mag;
        n_distl     = r_distl;
        n_distr     = r_distr;
        n_dth       = r_dth;
        n_ang       = r_ang;
        n_cos       = r_cos;
        n_sin       = r_sin;
        n_rnum      = r_rnum;
        n_vlin      = r_vlin;
        n_vang      = r_vang;
        n_vres      = r_vres;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ddo_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_last_l = i_in_item.left_count;
                    n_last_r = i_in_item.right_count;
                    n_dt     = i_in_item.elapsed_us;
                    n_dl_neg = dl[17];
                    n_dl_mag = dl[17] ? 17'(-dl) : 17'(dl);
                    n_dr_neg = dr[17];
                    n_dr_mag = dr[17] ? 17'(-dr) : 17'(dr);
                    n_primed = 1'b1;
                    // priming item: report pose unchanged and zero speeds
                    n_vres   = r_primed;
                    n_vlin   = 32'd0;
                    n_vang   = 32'd0;
                end
            end
            ddo_pkg::ST_DIST_L: begin
                if (mul_done) begin
                    n_distl = r_dl_neg ? -$signed(dist_p) : $signed(dist_p);
                end
            end
            ddo_pkg::ST_DIST_R: begin
                if (mul_done) begin
                    n_distr = r_dr_neg ? -$signed(dist_p) : $signed(dist_p);
                end
            end
            ddo_pkg::ST_TURN: begin
                if (mul_done) begin
                    n_dth = diff_neg ? -$signed({1'b0, mul_p[82:27]})
                                     : $signed({1'b0, mul_p[82:27]});
                end
            end
            ddo_pkg::ST_WRAP_A: begin
                if (div_done) begin
                    n_ang = ddo_pkg::wrap_fix(ang_v[57], div_rem);
                end
            end
            ddo_pkg::ST_ROTATE: begin
                if (cor_done) begin
                    n_cos = cor_cos;
                    n_sin = cor_sin;
                end
            end
            ddo_pkg::ST_STEP_X: begin
                if (mul_done) begin
                    n_x = r_x + (inc_neg ? (32'd0 - inc_mag) : inc_mag);
                end
            end
            ddo_pkg::ST_STEP_Y: begin
                if (mul_done) begin
                    n_y = r_y + (inc_neg ? (32'd0 - inc_mag) : inc_mag);
                end
            end
            ddo_pkg::ST_WRAP_H: begin
                if (div_done) begin
                    n_theta = ddo_pkg::wrap_fix(ang_v[57], div_rem);
                end
            end
            ddo_pkg::ST_LIN_MUL, ddo_pkg::ST_ANG_MUL: begin
                if (mul_done) begin
                    n_rnum = mul_p[ddo_pkg::RNUM_W-1:0];
                end
            end
            ddo_pkg::ST_LIN_DIV: begin
                if (div_done) begin
                    n_vlin = (r_dt == 24'd0) ? 32'd0 :
                             ddo_pkg::rate_fix(trav_neg,
                                 div_quo[ddo_pkg::RNUM_W-1:0] >> ddo_pkg::LIN_SHIFT);
                end
            end
            ddo_pkg::ST_ANG_DIV: begin
                if (div_done) begin
                    n_vang = (r_dt == 24'd0) ? 32'd0 :
                             ddo_pkg::rate_fix(dth_neg,
                                 div_quo[ddo_pkg::RNUM_W-1:0] >> ddo_pkg::ANG_SHIFT);
                end
            end
            ddo_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_item.valid_res       = r_vres;
                    n_out_item.pos_x           = $signed(r_x);
                    n_out_item.pos_y           = $signed(r_y);
                    n_out_item.heading         = $signed(r_theta);
                    n_out_item.linear_speed    = $signed(r_vlin);
                    n_out_item.angular_speed   = $signed(r_vang);
                end
            end
            default: begin
                n_vres = r_vres;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ddo_pkg::ST_IDLE;
            r_issued    <= 1'b0;
            r_mpc       <= ddo_pkg::MPC_RST;
            r_itw       <= ddo_pkg::ITW_RST;
            r_thr       <= ddo_pkg::THR_RST;
            r_primed    <= 1'b0;
            r_last_l    <= 16'd0;
            r_last_r    <= 16'd0;
            r_x         <= 32'd0;
            r_y         <= 32'd0;
            r_theta     <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_primed    <= n_primed;
            r_last_l    <= n_last_l;
            r_last_r    <= n_last_r;
            r_x         <= n_x;
            r_y         <= n_y;
            r_theta     <= n_theta;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ddo_pkg::CFG_MPC: r_mpc <= i_cfg_data;
                    ddo_pkg::CFG_ITW: r_itw <= i_cfg_data;
                    ddo_pkg::CFG_THR: r_thr <= i_cfg_data[15:0];
                    default:          r_thr <= r_thr;
                endcase
            end
        end
        r_dt       <= n_dt;
        r_dl_neg   <= n_dl_neg;
        r_dl_mag   <= n_dl_mag;
        r_dr_neg   <= n_dr_neg;
        r_dr_mag   <= n_dr_mag;
        r_distl    <= n_distl;
        r_distr    <= n_distr;
        r_dth      <= n_dth;
        r_ang      <= n_ang;
        r_cos      <= n_cos;
        r_sin      <= n_sin;
        r_rnum     <= n_rnum;
        r_vlin     <= n_vlin;
        r_vang     <= n_vang;
        r_vres     <= n_vres;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ---------------- assertions ----------------
    // a priming item goes straight to the result stage
    a_prime_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_primed) |=> (r_state == ddo_pkg::ST_DONE))
        else $error("priming item did not skip the arithmetic");

    // stored heading always lies in (-pi, pi]
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($signed(r_theta) <= $signed(ddo_pkg::PI_Q29)) &&
        ($signed(r_theta) > -$signed(ddo_pkg::PI_Q29)))
        else $error("heading out of range");

    // only one shared unit is launched at a time
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({mul_start, div_start, cor_start}) <= 1)
        else $error("two units launched together");

    // leaving the result stage always leaves a result item in the register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ddo_pkg::ST_DONE && out_free) |=> o_out_valid)
        else $error("result not loaded");

endmodule

### sim/diff_drive_odometry_tb.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_tb
// Self-checking bench for the wheel odometry block. A directed table covers
// the priming sample, zero motion, zero and maximum elapsed time, counter wrap
// on both wheels and the threshold edge. Random encoder traces follow under
// several register settings, including the extremes. Every result item is
// checked field by field against a fixed-point pose tracker kept in the bench.
// ----------------------------------------------------------------------------
module diff_drive_odometry_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddo_pkg::*;

    // angle constants widened for 64-bit math
    localparam longint PI_L      = longint'(PI_Q29);
    localparam longint HALF_PI_L = longint'(HALF_PI_Q29);
    localparam longint TWO_PI_L  = longint'(TWO_PI_Q29);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    diff_drive_odometry uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit: well beyond 700 items with the longest input and result gaps
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Pose tracker: its own copy of registers and state
    // ------------------------------------------------------------------------
    logic [31:0] m_per_cnt;
    logic [31:0] inv_track;
    logic [15:0] wrap_thr;
    bit          seeded;
    int          prev_l;
    int          prev_r;
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    longint      theta;
    longint      arctan_tab [CORDIC_STEPS];

    t_out_item   pose_queue [$];
    int          errors;
    bit          quiet;       // no idling on either side for this stretch
    int          rx_wait;

    // atan(2^-i) in Q29, odd series in Q62, rounded
    function automatic longint arctan_q29(int unsigned i);
        logic [63:0] acc;
        logic [63:0] term;
        acc = 64'd0;
        if (i == 0) begin
            return 64'd421657428;
        end
        for (int unsigned k = 1; i * k < 62; k += 2) begin
            term = (64'd1 << 62 >> (i * k)) / 64'(k);
            acc  = ((k >> 1) & 1) ? acc - term : acc + term;
        end
        return longint'((acc + 64'h1_0000_0000) >> 33);
    endfunction

    // signed a*b / 2^s truncated toward zero
    function automatic longint mul_trunc(longint a, longint b, int s);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        longint       r;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        p  = ({64'd0, ma} * {64'd0, mb}) >> s;
        r  = longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    // reduce to (-pi, pi]
    function automatic longint angle_wrap(longint v);
        longint r;
        r = v % TWO_PI_L;
        if (r < 0) r += TWO_PI_L;
        if (r > PI_L) r -= TWO_PI_L;
        return r;
    endfunction

    // Q29 angle -> Q30 cosine and sine
    task automatic cordic_rotate(input longint ang, output longint c, output longint s);
        longint cx;
        longint cy;
        longint z;
        longint xs;
        longint ys;
        bit     flip;
        cx = longint'(CORDIC_GAIN);
        cy = 0;
        z  = ang;
        flip = 1'b0;
        if (z > HALF_PI_L) begin
            z -= PI_L;
            flip = 1'b1;
        end else if (z < -HALF_PI_L) begin
            z += PI_L;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (z >= 0) begin
                cx -= ys;
                cy += xs;
                z  -= arctan_tab[i];
            end else begin
                cx += ys;
                cy -= xs;
                z  += arctan_tab[i];
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
    endtask

    // v * 1e6 / dt >> sh, truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] per_second(longint v, logic [23:0] dt, int sh);
        logic [63:0] m;
        logic [63:0] lim;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] t;
        if (dt == 24'd0) begin
            return 32'd0;
        end
        m   = (v < 0) ? 64'(-v) : 64'(v);
        lim = (v < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q   = m / 64'(dt);
        r   = m % 64'(dt);
        if (q >= (64'd1 << 43)) begin
            t = lim;
        end else begin
            t = (q * 64'(US_PER_S) + (r * 64'(US_PER_S)) / 64'(dt)) >> sh;
            if (t > lim) t = lim;
        end
        return (v < 0) ? (32'd0 - t[31:0]) : t[31:0];
    endfunction

    function automatic int unwrap_delta(int d);
        int t;
        t = int'(wrap_thr);
        if (d > t) return d - COUNT_SPAN;
        if (d < -t) return d + COUNT_SPAN;
        return d;
    endfunction

    // advance the tracked pose by one encoder sample
    task automatic odometry_step(input t_in_item it, output t_out_item res);
        int     dl;
        int     dr;
        longint dist_l;
        longint dist_r;
        longint travel;
        longint dth;
        longint c;
        longint s;
        longint dx;
        longint dy;
        res = '0;
        if (!seeded) begin
            seeded = 1'b1;
            prev_l = int'(it.left_count);
            prev_r = int'(it.right_count);
        end else begin
            dl = unwrap_delta(int'(it.left_count) - prev_l);
            dr = unwrap_delta(int'(it.right_count) - prev_r);
            prev_l = int'(it.left_count);
            prev_r = int'(it.right_count);
            dist_l = longint'(dl) * longint'(m_per_cnt);
            dist_r = longint'(dr) * longint'(m_per_cnt);
            travel = (dist_l + dist_r) >>> 1;
            dth    = mul_trunc(dist_r - dist_l, longint'(inv_track), 27);
            cordic_rotate(angle_wrap(theta - dth), c, s);
            dx = mul_trunc(travel, c, 46);
            dy = mul_trunc(travel, s, 46);
            x_pos += dx[31:0];
            y_pos += dy[31:0];
            theta  = angle_wrap(theta + dth);
            res.valid_res     = 1'b1;
            res.linear_speed  = per_second(travel, it.elapsed_us, LIN_SHIFT);
            res.angular_speed = per_second(dth, it.elapsed_us, ANG_SHIFT);
        end
        res.pos_x   = x_pos;
        res.pos_y   = y_pos;
        res.heading = theta[31:0];
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, in-order compare
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pose_queue.size() == 0) begin
                    $display("%0t: result item with none expected: %p", $time, o_out_item);
                    errors++;
                end else begin
                    want = pose_queue.pop_front();
                    if (o_out_item.valid_res !== want.valid_res) begin
                        $display("%0t: valid_res exp %0d got %0d", $time,
                                 want.valid_res, o_out_item.valid_res);
                        errors++;
                    end
                    if (o_out_item.pos_x !== want.pos_x) begin
                        $display("%0t: pos_x exp %0d got %0d", $time,
                                 want.pos_x, o_out_item.pos_x);
                        errors++;
                    end
                    if (o_out_item.pos_y !== want.pos_y) begin
                        $display("%0t: pos_y exp %0d got %0d", $time,
                                 want.pos_y, o_out_item.pos_y);
                        errors++;
                    end
                    if (o_out_item.heading !== want.heading) begin
                        $display("%0t: heading exp %0d got %0d", $time,
                                 want.heading, o_out_item.heading);
                        errors++;
                    end
                    if (o_out_item.linear_speed !== want.linear_speed) begin
                        $display("%0t: linear_speed exp %0d got %0d", $time,
                                 want.linear_speed, o_out_item.linear_speed);
                        errors++;
                    end
                    if (o_out_item.angular_speed !== want.angular_speed) begin
                        $display("%0t: angular_speed exp %0d got %0d", $time,
                                 want.angular_speed, o_out_item.angular_speed);
                        errors++;
                    end
                end
                rx_wait = quiet ? 0 : $urandom_range(0, 17);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_out_stall <= (rx_wait > 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Send one item; typed rows replace the tracker's result with a fixed one.
    task automatic send_sample(input t_in_item it, input bit typed, input bit vld);
        t_out_item res;
        int        gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        odometry_step(it, res);
        if (typed) begin
            res = '0;
            res.valid_res = vld;
        end
        pose_queue.push_back(res);
    endtask

    // Registers change only with nothing in flight.
    task automatic write_regs(input logic [31:0] mpc, input logic [31:0] itw,
                              input logic [15:0] thr);
        i_in_valid <= 1'b0;
        while (pose_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MPC;
        i_cfg_data  <= mpc;
        @(posedge i_clk);
        i_cfg_index <= CFG_ITW;
        i_cfg_data  <= itw;
        @(posedge i_clk);
        i_cfg_index <= CFG_THR;
        i_cfg_data  <= {16'd0, thr};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_per_cnt = mpc;
        inv_track = itw;
        wrap_thr  = thr;
    endtask

    logic [15:0] trace_l;
    logic [15:0] trace_r;

    // mostly plausible wheel motion, with wrap-sized jumps and noise mixed in
    task automatic random_run(input int n);
        t_in_item it;
        int       base;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    base = $urandom_range(0, 6000) - 3000;
                    trace_l += 16'(base + $urandom_range(0, 400) - 200);
                    trace_r += 16'(base + $urandom_range(0, 400) - 200);
                end
                6, 7: begin
                    trace_l += 16'($urandom_range(0, 65535));
                    trace_r += 16'($urandom_range(25000, 40000));
                end
                8: begin
                    trace_l = 16'($urandom);
                    trace_r = 16'($urandom);
                end
                default: ;
            endcase
            it.left_count  = trace_l;
            it.right_count = trace_r;
            case ($urandom_range(0, 15))
                0:       it.elapsed_us = 24'd0;
                1:       it.elapsed_us = 24'd1;
                2:       it.elapsed_us = 24'hFFFFFF;
                3, 4:    it.elapsed_us = 24'($urandom);
                default: it.elapsed_us = 24'($urandom_range(1000, 200000));
            endcase
            send_sample(it, 1'b0, 1'b0);
        end
    endtask

    typedef struct {
        t_in_item it;
        bit       typed;
        bit       vld;
    } t_row;

    t_row directed [$];

    task automatic add_row(input int l, input int r, input int dt,
                           input bit typed, input bit vld);
        t_row row;
        row.it.left_count  = 16'(l);
        row.it.right_count = 16'(r);
        row.it.elapsed_us  = 24'(dt);
        row.typed = typed;
        row.vld   = vld;
        directed.push_back(row);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MPC;
        i_cfg_data  = '0;
        errors  = 0;
        quiet   = 1'b0;
        rx_wait = 0;
        seeded  = 1'b0;
        prev_l  = 0;
        prev_r  = 0;
        x_pos   = '0;
        y_pos   = '0;
        theta   = 0;
        m_per_cnt = MPC_RST;
        inv_track = ITW_RST;
        wrap_thr  = THR_RST;
        for (int i = 0; i < CORDIC_STEPS; i++) arctan_tab[i] = arctan_q29(i);

        // priming, then zero motion at max and zero elapsed time
        add_row(100, 200, 1000, 1, 0);
        add_row(100, 200, 16777215, 1, 1);
        add_row(100, 200, 0, 1, 1);
        // straight, turn, and both counters wrapping each way
        add_row(1100, 1200, 20000, 0, 0);
        add_row(1100, 2200, 50000, 0, 0);
        add_row(65535, 0, 1, 0, 0);
        add_row(0, 65535, 1, 0, 0);
        // delta exactly at threshold on the left, one past it on the right
        add_row(30000, 35534, 40000, 0, 0);
        add_row(0, 0, 16777215, 0, 0);
        add_row(65535, 65535, 0, 0, 0);
        add_row(32768, 0, 12345, 0, 0);
        add_row(0, 32768, 1, 0, 0);
        add_row(20000, 12000, 1, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_sample(directed[i].it, directed[i].typed, directed[i].vld);
        trace_l = 16'd20000;
        trace_r = 16'd12000;

        // register settings: reset values first, extremes in between
        random_run(140);
        write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
        random_run(130);
        write_regs(32'd0, 32'd0, 16'hFFFF);
        random_run(60);
        write_regs(32'($urandom), 32'($urandom), 16'($urandom));
        random_run(130);
        write_regs(32'd4_000_000, 32'd400_000_000, 16'hFFFF);
        random_run(110);
        write_regs(MPC_RST, ITW_RST, THR_RST);
        random_run(120);

        i_in_valid <= 1'b0;
        while (pose_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
design/ddo_pkg.sv
design/ddo_mul.sv
design/ddo_div.sv
design/ddo_cordic.sv
design/diff_drive_odometry.sv
sim/diff_drive_odometry_tb.sv
